// File: rtl/core/dgat_pkg.sv
// shared types and constants for the dual-grid autotile table
// no dependencies; used by the top level, dgat_ctrl and dgat_datapath
`default_nettype none

package dgat_pkg;

    // command codes carried by a request transaction
    typedef enum logic [1:0] {
        CMD_SET_TILE    = 2'd0,
        CMD_READ_TILE   = 2'd1,
        CMD_UPDATE      = 2'd2,
        CMD_READ_SPRITE = 2'd3
    } cmd_t;

    // configuration register indexes
    localparam logic [1:0] REG_MAP_WIDTH    = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_SPRITE_TABLE = 2'd2;

    // configuration reset values
    localparam logic [6:0]  MAP_WIDTH_RESET    = 7'd64;
    localparam logic [6:0]  MAP_HEIGHT_RESET   = 7'd64;
    localparam logic [63:0] SPRITE_TABLE_RESET = 64'hAEB7_9F2C_6853_D140;

    // highest tile value a set command may write (dirt or grass)
    localparam logic [7:0] TILE_VALUE_MAX = 8'd1;

    // request payload
    typedef struct packed {
        cmd_t       command;
        logic [5:0] tile_x;
        logic [5:0] tile_y;
        logic [7:0] tile_value;
    } req_item_t;

    // response payload
    typedef struct packed {
        logic [3:0] read_value;
        logic       accepted;
    } rsp_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic clear;   // clearing sweep step
        logic start;   // request transaction accepted this cycle
        logic finish;  // load the response register this cycle
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;  // last entry of the clearing sweep
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/dual_grid_autotile_table.sv
// top level of the dual-grid autotile table: controller plus datapath
// depends on dgat_pkg, dgat_ctrl, dgat_datapath (and dgat_ram below it)
//
// Usage:
//   req (valid/ready) carries one command transaction: set tile, read tile,
//   update sprite from the 2x2 corner tiles, or read sprite. rsp (valid/ready)
//   returns exactly one transaction per request with read_value and accepted.
//   cfg_we/cfg_index/cfg_wdata write map_width, map_height and sprite_table,
//   selected by cfg_index; write them only while no request is in flight.
//   A request is taken in ST_IDLE, the four parity-banked tile rams and the
//   sprite ram are read into registers, and in ST_EXEC the result is loaded
//   into the response register; no new request is taken until then.
//   Reset: both stores are cleared by a sweep with req_ready low;
//   configuration writes are still taken during the sweep.
//   Stall: a finished response waits in its output register; one further
//   request is still accepted and holds until the response is taken.
`default_nettype none

module dual_grid_autotile_table #(
    parameter int unsigned MAX_COLUMNS = 64,
    parameter int unsigned MAX_ROWS    = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [63:0]           cfg_wdata,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire dgat_pkg::req_item_t   req,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output dgat_pkg::rsp_item_t        rsp
);

    dgat_pkg::ctrl_cmd_t  cmd;
    dgat_pkg::dp_status_t status;

    // sequencing and handshake
    dgat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // stores, lookup and response
    dgat_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    // an accepted request is never followed by another one back to back
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted back to back");

    // a rejected command never returns data
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.accepted |-> rsp.read_value == 4'd0)
        else $error("rejected response carries data");

    // a new response only follows execution, with req_ready low before it
    a_rsp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response appeared without execution");
`endif

endmodule

`default_nettype wire

// File: rtl/core/dgat_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module dgat_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 2,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, data held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/dgat_ctrl.sv
// controller: clearing sweep, request/response handshake and sequencing
// depends on dgat_pkg
`default_nettype none

module dgat_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    input  wire dgat_pkg::dp_status_t   status,
    output dgat_pkg::ctrl_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   slot_free;

    // response register can take a new transaction
    assign slot_free = !rsp_valid_reg || rsp_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.start = req_valid;
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.finish = slot_free;
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // response valid flag
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

// File: rtl/core/dgat_datapath.sv
// datapath: configuration registers, parity-banked tile store, sprite store,
// key lookup and response register; depends on dgat_pkg and dgat_ram
`default_nettype none

module dgat_datapath #(
    parameter int unsigned MAX_COLUMNS = 64,
    parameter int unsigned MAX_ROWS    = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dgat_pkg::ctrl_cmd_t   cmd,
    output dgat_pkg::dp_status_t       status,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [63:0]           cfg_wdata,
    input  wire dgat_pkg::req_item_t   req,
    output dgat_pkg::rsp_item_t        rsp
);

    localparam int unsigned DEPTH      = MAX_COLUMNS * MAX_ROWS;
    localparam int unsigned AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned BANK_COLS  = (MAX_COLUMNS + 1) / 2;
    localparam int unsigned BANK_ROWS  = (MAX_ROWS + 1) / 2;
    localparam int unsigned BANK_DEPTH = BANK_COLS * BANK_ROWS;
    localparam int unsigned TAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    // configuration registers
    logic [6:0]  map_width_reg;
    logic [6:0]  map_height_reg;
    logic [63:0] sprite_table_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg    <= dgat_pkg::MAP_WIDTH_RESET;
            map_height_reg   <= dgat_pkg::MAP_HEIGHT_RESET;
            sprite_table_reg <= dgat_pkg::SPRITE_TABLE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dgat_pkg::REG_MAP_WIDTH:    map_width_reg    <= cfg_wdata[6:0];
                dgat_pkg::REG_MAP_HEIGHT:   map_height_reg   <= cfg_wdata[6:0];
                dgat_pkg::REG_SPRITE_TABLE: sprite_table_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // clearing sweep counter
    logic [AW-1:0] clr_cnt_reg;
    logic          clr_tile;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign status.clear_last = (clr_cnt_reg == AW'(DEPTH - 1));
    assign clr_tile          = cmd.clear && (32'(clr_cnt_reg) < BANK_DEPTH);

    // position checks against the map in use
    logic [6:0] x_p1;
    logic [6:0] y_p1;
    logic       in_map;
    logic       in_area;
    logic       value_ok;
    logic       req_ok;

    assign x_p1     = {1'b0, req.tile_x} + 7'd1;
    assign y_p1     = {1'b0, req.tile_y} + 7'd1;
    assign in_map   = ({1'b0, req.tile_x} < map_width_reg) && (32'(req.tile_x) < MAX_COLUMNS)
                   && ({1'b0, req.tile_y} < map_height_reg) && (32'(req.tile_y) < MAX_ROWS);
    assign in_area  = (x_p1 < map_width_reg) && (32'(x_p1) < MAX_COLUMNS)
                   && (y_p1 < map_height_reg) && (32'(y_p1) < MAX_ROWS);
    assign value_ok = (req.tile_value <= dgat_pkg::TILE_VALUE_MAX);

    always_comb
    begin
        case (req.command)
            dgat_pkg::CMD_SET_TILE:  req_ok = in_map && value_ok;
            dgat_pkg::CMD_READ_TILE: req_ok = in_map;
            default:                 req_ok = in_area;
        endcase
    end

    // tile banks, one per column and row parity; bank b = {row parity, column parity}
    logic          tile_rd [4];
    logic          set_we;

    assign set_we = cmd.start && (req.command == dgat_pkg::CMD_SET_TILE) && req_ok;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [6:0]     col;
        logic [6:0]     row;
        logic [TAW-1:0] addr;
        logic           own;
        logic           we;
        logic [TAW-1:0] waddr;

        // column and row of the 2x2 neighbourhood that falls into this bank
        assign col  = (req.tile_x[0] == b[0]) ? {1'b0, req.tile_x} : x_p1;
        assign row  = (req.tile_y[0] == b[1]) ? {1'b0, req.tile_y} : y_p1;
        assign addr = TAW'(32'(col[6:1]) + 32'(row[6:1]) * BANK_COLS);
        assign own  = (req.tile_x[0] == b[0]) && (req.tile_y[0] == b[1]);

        assign we    = clr_tile || (set_we && own);
        assign waddr = cmd.clear ? clr_cnt_reg[TAW-1:0] : addr;

        dgat_ram #(
            .WIDTH (1),
            .DEPTH (BANK_DEPTH)
        ) u_tile_bank (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (req.tile_value[0] && !cmd.clear),
            .re    (cmd.start),
            .raddr (addr),
            .rdata (tile_rd[b])
        );
    end

    // transaction context held while the stores are read
    dgat_pkg::cmd_t cmd_reg;
    logic           ok_reg;
    logic           x0_reg;
    logic           y0_reg;
    logic [AW-1:0]  saddr_reg;
    logic [AW-1:0]  saddr;

    assign saddr = AW'(32'(req.tile_x) + 32'(req.tile_y) * MAX_COLUMNS);

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            cmd_reg   <= req.command;
            ok_reg    <= req_ok;
            x0_reg    <= req.tile_x[0];
            y0_reg    <= req.tile_y[0];
            saddr_reg <= saddr;
        end
    end

    // key from the 2x2 corner tiles and table lookup
    logic [3:0] key;
    logic [3:0] sprite_idx;
    logic [3:0] sprite_rd;

    assign key[3] = tile_rd[{y0_reg, x0_reg}];
    assign key[2] = tile_rd[{!y0_reg, x0_reg}];
    assign key[1] = tile_rd[{y0_reg, !x0_reg}];
    assign key[0] = tile_rd[{!y0_reg, !x0_reg}];
    assign sprite_idx = sprite_table_reg[{key, 2'b00} +: 4];

    // sprite store
    logic          spr_we;
    logic [AW-1:0] spr_waddr;

    assign spr_we    = cmd.clear
                    || (cmd.finish && ok_reg && (cmd_reg == dgat_pkg::CMD_UPDATE));
    assign spr_waddr = cmd.clear ? clr_cnt_reg : saddr_reg;

    dgat_ram #(
        .WIDTH (4),
        .DEPTH (DEPTH)
    ) u_sprite_store (
        .clk   (clk),
        .we    (spr_we),
        .waddr (spr_waddr),
        .wdata (cmd.clear ? 4'd0 : sprite_idx),
        .re    (cmd.start),
        .raddr (saddr),
        .rdata (sprite_rd)
    );

    // response register
    dgat_pkg::rsp_item_t rsp_reg;
    dgat_pkg::rsp_item_t rsp_next;

    always_comb
    begin
        rsp_next.accepted   = ok_reg;
        rsp_next.read_value = 4'd0;
        if (ok_reg)
        begin
            case (cmd_reg)
                dgat_pkg::CMD_READ_TILE:   rsp_next.read_value = {3'd0, key[3]};
                dgat_pkg::CMD_READ_SPRITE: rsp_next.read_value = sprite_rd;
                default:                   rsp_next.read_value = 4'd0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// File: dv/dual_grid_autotile_table_tb.sv
// testbench for the dual-grid autotile table: directed and random tile traffic
// checked against an in-bench model of the tile and sprite stores
// depends on dgat_pkg and dual_grid_autotile_table
module dual_grid_autotile_table_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
    // cycles without any transaction before the run is abandoned
    // (covers the clearing sweep after reset several times over)
    localparam int STALL_LIMIT = 20000;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [1:0]          cfg_index = dgat_pkg::REG_MAP_WIDTH;
    logic [63:0]         cfg_wdata = '0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    dgat_pkg::req_item_t req       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    dgat_pkg::rsp_item_t rsp;

    // model copy of configuration and stores
    logic [6:0]  cur_width   = dgat_pkg::MAP_WIDTH_RESET;
    logic [6:0]  cur_height  = dgat_pkg::MAP_HEIGHT_RESET;
    logic [63:0] cur_sprites = dgat_pkg::SPRITE_TABLE_RESET;
    logic        tile_map [CELLS];
    logic [3:0]  atlas_model [CELLS];

    dgat_pkg::rsp_item_t pending_responses [$];
    dgat_pkg::rsp_item_t oldest_response;
    int                  error_count    = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;

    dual_grid_autotile_table #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // stores start cleared, as after the reset sweep
    initial
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            tile_map[i]    = 1'b0;
            atlas_model[i] = 4'd0;
        end
    end

    function automatic int width_in_use();
        return (int'(cur_width) > MAX_COLUMNS) ? MAX_COLUMNS : int'(cur_width);
    endfunction

    function automatic int height_in_use();
        return (int'(cur_height) > MAX_ROWS) ? MAX_ROWS : int'(cur_height);
    endfunction

    // tile bit at a position, zero outside the map in use
    function automatic logic tile_bit(int x, int y, int w, int h);
        if (x >= w || y >= h)
            return 1'b0;
        return tile_map[x + y * MAX_COLUMNS];
    endfunction

    // applies one command to the model stores and returns its response
    function automatic dgat_pkg::rsp_item_t autotile_response(dgat_pkg::req_item_t item);
        int                  w;
        int                  h;
        int                  x;
        int                  y;
        int                  addr;
        logic                in_map;
        logic                in_area;
        logic [3:0]          key;
        dgat_pkg::rsp_item_t r;
        w       = width_in_use();
        h       = height_in_use();
        x       = item.tile_x;
        y       = item.tile_y;
        addr    = x + y * MAX_COLUMNS;
        in_map  = (x < w) && (y < h);
        in_area = (x + 1 < w) && (y + 1 < h);
        r       = '0;
        case (item.command)
            dgat_pkg::CMD_SET_TILE:
            begin
                if (in_map && item.tile_value <= dgat_pkg::TILE_VALUE_MAX)
                begin
                    tile_map[addr] = item.tile_value[0];
                    r.accepted     = 1'b1;
                end
            end
            dgat_pkg::CMD_READ_TILE:
            begin
                if (in_map)
                begin
                    r.read_value = {3'd0, tile_bit(x, y, w, h)};
                    r.accepted   = 1'b1;
                end
            end
            dgat_pkg::CMD_UPDATE:
            begin
                if (in_area)
                begin
                    // corner order: (x,y), (x,y+1), (x+1,y), (x+1,y+1) from msb down
                    key = {tile_bit(x, y, w, h), tile_bit(x, y + 1, w, h),
                           tile_bit(x + 1, y, w, h), tile_bit(x + 1, y + 1, w, h)};
                    atlas_model[addr] = cur_sprites[key * 4 +: 4];
                    r.accepted        = 1'b1;
                end
            end
            default:
            begin
                if (in_area)
                begin
                    r.read_value = atlas_model[addr];
                    r.accepted   = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic dgat_pkg::req_item_t make_item(dgat_pkg::cmd_t c, int x, int y,
                                                      int v);
        dgat_pkg::req_item_t item;
        item.command    = c;
        item.tile_x     = x[5:0];
        item.tile_y     = y[5:0];
        item.tile_value = v[7:0];
        return item;
    endfunction

    // sends one request transaction and records its expected response
    task automatic send_request(input dgat_pkg::req_item_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        pending_responses.push_back(autotile_response(item));
    endtask

    // waits until every response is back, then lets the block settle
    task automatic drain_responses(input int settle);
        req_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // writes all three registers on consecutive cycles; block must be idle
    task automatic write_config(input logic [6:0] width, input logic [6:0] height,
                                input logic [63:0] sprite_bits);
        cfg_we    <= 1'b1;
        cfg_index <= dgat_pkg::REG_MAP_WIDTH;
        cfg_wdata <= {57'd0, width};
        @(posedge clk);
        cfg_index <= dgat_pkg::REG_MAP_HEIGHT;
        cfg_wdata <= {57'd0, height};
        @(posedge clk);
        cfg_index <= dgat_pkg::REG_SPRITE_TABLE;
        cfg_wdata <= sprite_bits;
        @(posedge clk);
        cfg_we      <= 1'b0;
        cur_width   = width;
        cur_height  = height;
        cur_sprites = sprite_bits;
    endtask

    // reset configuration: reads of cleared stores, bad values, updates
    task automatic test_directed_defaults();
        send_request(make_item(dgat_pkg::CMD_READ_TILE, 0, 0, 0));
        send_request(make_item(dgat_pkg::CMD_READ_SPRITE, 0, 0, 0));
        send_request(make_item(dgat_pkg::CMD_SET_TILE, 63, 63, 1));
        send_request(make_item(dgat_pkg::CMD_READ_TILE, 63, 63, 0));
        send_request(make_item(dgat_pkg::CMD_SET_TILE, 0, 0, 2));
        send_request(make_item(dgat_pkg::CMD_SET_TILE, 0, 0, 255));
        send_request(make_item(dgat_pkg::CMD_SET_TILE, 0, 0, 1));
        send_request(make_item(dgat_pkg::CMD_SET_TILE, 1, 1, 1));
        send_request(make_item(dgat_pkg::CMD_UPDATE, 0, 0, 0));
        send_request(make_item(dgat_pkg::CMD_READ_SPRITE, 0, 0, 0));
        send_request(make_item(dgat_pkg::CMD_UPDATE, 62, 62, 0));
        send_request(make_item(dgat_pkg::CMD_READ_SPRITE, 62, 62, 0));
        // corners beyond the sprite area
        send_request(make_item(dgat_pkg::CMD_UPDATE, 63, 0, 0));
        send_request(make_item(dgat_pkg::CMD_READ_SPRITE, 0, 63, 0));
        drain_responses(4);
    endtask

    // single-tile map, zero width and oversized registers
    task automatic test_map_limits();
        write_config(7'd1, 7'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(make_item(dgat_pkg::CMD_SET_TILE, 0, 0, 0));
        send_request(make_item(dgat_pkg::CMD_SET_TILE, 1, 0, 1));
        send_request(make_item(dgat_pkg::CMD_READ_TILE, 0, 1, 0));
        send_request(make_item(dgat_pkg::CMD_UPDATE, 0, 0, 0));
        drain_responses(4);
        write_config(7'd0, 7'd64, 64'h0);
        send_request(make_item(dgat_pkg::CMD_SET_TILE, 0, 0, 1));
        send_request(make_item(dgat_pkg::CMD_READ_TILE, 0, 0, 0));
        drain_responses(4);
        // sizes above the store clamp to the full map
        write_config(7'd127, 7'd100, 64'hFEDC_BA98_7654_3210);
        send_request(make_item(dgat_pkg::CMD_SET_TILE, 63, 63, 0));
        send_request(make_item(dgat_pkg::CMD_UPDATE, 62, 62, 0));
        send_request(make_item(dgat_pkg::CMD_READ_SPRITE, 62, 62, 0));
        drain_responses(4);
        write_config(7'd2, 7'd2, 64'h0123_4567_89AB_CDEF);
        send_request(make_item(dgat_pkg::CMD_UPDATE, 0, 0, 0));
        send_request(make_item(dgat_pkg::CMD_READ_SPRITE, 0, 0, 0));
        send_request(make_item(dgat_pkg::CMD_UPDATE, 1, 0, 0));
        drain_responses(4);
    endtask

    // coordinate mostly inside a small window so commands interact,
    // sometimes at the map border, sometimes anywhere
    function automatic int pick_coord(int size, int base);
        int r;
        int c;
        r = $urandom_range(9);
        if (r < 2)
            return $urandom_range(63);
        if (r < 4)
        begin
            c = size - 2 + int'($urandom_range(3));
            return (c < 0) ? 0 : ((c > 63) ? 63 : c);
        end
        return base + $urandom_range(3);
    endfunction

    // random commands over three map settings
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int                  w;
        int                  h;
        int                  base_x;
        int                  base_y;
        int                  pick;
        dgat_pkg::req_item_t item;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int seg = 0; seg < 3; seg++)
        begin
            case (seg)
                0: write_config(7'd64, 7'd64, {$urandom, $urandom});
                1: write_config(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)),
                                {$urandom, $urandom});
                default: write_config(7'($urandom_range(2, 6)), 7'($urandom_range(2, 6)),
                                      {$urandom, $urandom});
            endcase
            w      = width_in_use();
            h      = height_in_use();
            base_x = (w > 4) ? $urandom_range(w - 4) : 0;
            base_y = (h > 4) ? $urandom_range(h - 4) : 0;
            for (int i = 0; i < n_items / 3; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                    item.command = dgat_pkg::CMD_SET_TILE;
                else if (pick < 50)
                    item.command = dgat_pkg::CMD_READ_TILE;
                else if (pick < 80)
                    item.command = dgat_pkg::CMD_UPDATE;
                else
                    item.command = dgat_pkg::CMD_READ_SPRITE;
                item.tile_x     = 6'(pick_coord(w, base_x));
                item.tile_y     = 6'(pick_coord(h, base_y));
                item.tile_value = ($urandom_range(99) < 85) ? 8'($urandom_range(1))
                                                            : 8'($urandom_range(255));
                send_request(item);
            end
            drain_responses(4);
        end
    endtask

    // response checker and receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("response transaction with no request outstanding");
                error_count++;
            end
            else
            begin
                oldest_response = pending_responses.pop_front();
                if (rsp.read_value !== oldest_response.read_value)
                begin
                    $error("read_value: expected %0d, got %0d",
                           oldest_response.read_value, rsp.read_value);
                    error_count++;
                end
                if (rsp.accepted !== oldest_response.accepted)
                begin
                    $error("accepted: expected %0d, got %0d",
                           oldest_response.accepted, rsp.accepted);
                    error_count++;
                end
            end
        end
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transaction
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // test sequence
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_defaults();
        test_map_limits();
        test_random_traffic(600, 33, 53);
        test_random_traffic(600, 53, 33);
        test_random_traffic(600, 0, 0);
        drain_responses(10);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
